>>> rtl/sfr_pkg.sv
// Package with the constants, types and helper functions of the frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int PAYLOAD_BYTES = 22;
   localparam int FRAME_LENGTH  = 24;
   localparam int TIME_BITS     = 16;

   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 5;
   localparam int COUNT_W     = 5;
   localparam int STORE_IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   localparam logic [BYTE_W-1:0] HEADER_BYTE   = 8'h0F;
   localparam logic [BYTE_W-1:0] END_MARKER_0  = 8'h00;
   localparam logic [BYTE_W-1:0] END_MARKER_1  = 8'h04;
   localparam logic [BYTE_W-1:0] END_MARKER_2  = 8'h14;
   localparam logic [BYTE_W-1:0] END_MARKER_3  = 8'h24;
   localparam logic [BYTE_W-1:0] END_MARKER_4  = 8'h34;
   localparam logic [BYTE_W-1:0] GAP_LIMIT_RST = 8'd2;

   localparam logic [COUNT_W-1:0] COUNT_END  = COUNT_W'(FRAME_LENGTH - 1);
   localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(PAYLOAD_BYTES - 1);

   typedef struct packed {
      logic take_byte;
      logic clear_count;
      logic store_byte;
      logic emit_start;
      logic emit_next;
   } cmd_type;

   typedef struct packed {
      logic gap_exceeded;
      logic is_header;
      logic count_end;
      logic is_end_marker;
      logic emit_last;
   } status_type;

   function automatic logic end_marker(input logic [BYTE_W-1:0] b);
      return (b == END_MARKER_0) || (b == END_MARKER_1) || (b == END_MARKER_2) ||
             (b == END_MARKER_3) || (b == END_MARKER_4);
   endfunction

endpackage

>>> rtl/sfr_ifs.sv
// Interfaces of the byte request, result and configuration channels.
`timescale 1ns / 1ps

interface sfr_req_if import sfr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    data_byte;
   logic [TIME_BITS-1:0] time_ms;

   modport source (output valid, output data_byte, output time_ms, input ready);
   modport sink   (input valid, input data_byte, input time_ms, output ready);
endinterface

interface sfr_rsp_if import sfr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  frame_byte;
   logic [INDEX_W-1:0] byte_index;
   logic               last_byte;

   modport source (output valid, output frame_byte, output byte_index, output last_byte,
                   input ready);
   modport sink   (input valid, input frame_byte, input byte_index, input last_byte,
                   output ready);
endinterface

interface sfr_csr_if import sfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sfr_controller.sv
// Controller state machine that sequences frame reception and result emission.
`timescale 1ns / 1ps

module sfr_controller import sfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RECV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_fire;
   logic       rsp_fire;
   logic       in_frame;

   assign req_ready = (state_ff != ST_EMIT);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign in_frame  = (state_ff == ST_RECV) && !status.gap_exceeded;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE, ST_RECV: begin
            if (req_fire) begin
               cmd.take_byte = 1'b1;
               if (!in_frame) begin
                  if (status.is_header) begin
                     cmd.clear_count = 1'b1;
                     state_in        = ST_RECV;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  cmd.store_byte = 1'b1;
                  if (status.count_end) begin
                     cmd.clear_count = 1'b1;
                     if (status.is_end_marker) begin
                        cmd.emit_start = 1'b1;
                        state_in       = ST_EMIT;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/sfr_datapath.sv
// Datapath with the gap timer, byte counter, payload store and result index.
`timescale 1ns / 1ps

module sfr_datapath import sfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [BYTE_W-1:0]    data_byte,
   input  logic [TIME_BITS-1:0] time_ms,
   input  logic                 csr_write,
   input  logic [BYTE_W-1:0]    csr_data,
   output logic [BYTE_W-1:0]    frame_byte,
   output logic [INDEX_W-1:0]   byte_index,
   output logic                 last_byte
);

   logic [BYTE_W-1:0]    gap_limit_ff;
   logic [BYTE_W-1:0]    gap_limit_in;
   logic [TIME_BITS-1:0] last_time_ff;
   logic [TIME_BITS-1:0] last_time_in;
   logic [COUNT_W-1:0]   byte_count_ff;
   logic [COUNT_W-1:0]   byte_count_in;
   logic [INDEX_W-1:0]   emit_idx_ff;
   logic [INDEX_W-1:0]   emit_idx_in;
   logic [BYTE_W-1:0]    store_ff [PAYLOAD_BYTES];
   logic [TIME_BITS-1:0] gap;
   logic [COUNT_W-1:0]   count_next;
   logic                 store_we;

   assign gap        = time_ms - last_time_ff;
   assign count_next = byte_count_ff + COUNT_W'(1);
   assign store_we   = cmd.store_byte &&
                       ({1'b0, byte_count_ff} < (COUNT_W + 1)'(PAYLOAD_BYTES));

   assign status.gap_exceeded  = gap > TIME_BITS'(gap_limit_ff);
   assign status.is_header     = (data_byte == HEADER_BYTE);
   assign status.count_end     = count_next >= COUNT_END;
   assign status.is_end_marker = end_marker(data_byte);
   assign status.emit_last     = (emit_idx_ff == INDEX_LAST);

   assign frame_byte = store_ff[emit_idx_ff[STORE_IDX_W-1:0]];
   assign byte_index = emit_idx_ff;
   assign last_byte  = (emit_idx_ff == INDEX_LAST);

   always_comb begin
      gap_limit_in  = csr_write ? csr_data : gap_limit_ff;
      last_time_in  = cmd.take_byte ? time_ms : last_time_ff;
      byte_count_in = byte_count_ff;
      if (cmd.clear_count) begin
         byte_count_in = '0;
      end else if (cmd.store_byte) begin
         byte_count_in = count_next;
      end
      emit_idx_in = emit_idx_ff;
      if (cmd.emit_start) begin
         emit_idx_in = '0;
      end else if (cmd.emit_next) begin
         emit_idx_in = emit_idx_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff  <= GAP_LIMIT_RST;
         last_time_ff  <= '0;
         byte_count_ff <= '0;
         emit_idx_ff   <= '0;
      end else begin
         gap_limit_ff  <= gap_limit_in;
         last_time_ff  <= last_time_in;
         byte_count_ff <= byte_count_in;
         emit_idx_ff   <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[byte_count_ff[STORE_IDX_W-1:0]] <= data_byte;
      end
   end

endmodule

>>> rtl/sbus_frame_receiver.sv
// Top level of the serial frame receiver: controller plus datapath.
// Byte requests are accepted whenever no result run is pending.
// A good end marker starts a run of 22 results in the next cycle, one per cycle
// while the output is ready; byte requests are held off until the last result is taken.
// A frame is thus 24 request bytes giving 22 results, one result per handshake.
// Synchronous reset returns to waiting for a header, clears the counters and time,
// and sets the gap limit to 2 ms; the payload store is not cleared.
`timescale 1ns / 1ps

module sbus_frame_receiver import sfr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req_ch,
   sfr_rsp_if.source rsp_ch,
   sfr_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   sfr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .data_byte  (req_ch.data_byte),
      .time_ms    (req_ch.time_ms),
      .csr_write  (csr_ch.valid),
      .csr_data   (csr_ch.data),
      .frame_byte (rsp_ch.frame_byte),
      .byte_index (rsp_ch.byte_index),
      .last_byte  (rsp_ch.last_byte)
   );

endmodule

>>> rtl/sfr_checker.sv
// Port-level checker of the frame receiver and its bind to the top level.
`timescale 1ns / 1ps

module sfr_checker import sfr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [INDEX_W-1:0] byte_index,
   input logic               last_byte
);

   a_emit_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Byte request accepted during a result run.");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_byte == (byte_index == INDEX_LAST)))
      else $error("Last flag does not match the final payload index.");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !last_byte) |=>
         (rsp_valid && (byte_index == $past(byte_index) + INDEX_W'(1))))
      else $error("Result run skipped or repeated an index.");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && last_byte) |=> !rsp_valid)
      else $error("Result run continued past its last byte.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(byte_index)))
      else $error("Stalled result changed.");

endmodule

bind sbus_frame_receiver sfr_checker u_sfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .byte_index (rsp_ch.byte_index),
   .last_byte  (rsp_ch.last_byte)
);
